>>> design/bbpe_pkg.sv
// ----------------------------------------------------------------------------
// bbpe_pkg: shared definitions for the bicubic Bezier patch evaluator
// Types, codes and default sizes used by the controller, the datapath and
// the top level.
// ----------------------------------------------------------------------------
package bbpe_pkg;

   // Default sizes for the top-level parameters.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int GRID_MAX_DEF    = 1024;

   // Fixed field widths of the ports and command fields.
   localparam int GRID_REG_W = 11;
   localparam int IDX_W      = 10;
   localparam int CPT_IDX_W  = 4;
   localparam int TERM_W     = 4;
   localparam int WSEL_W     = 2;

   localparam logic [GRID_REG_W-1:0] GRID_RESET = 11'd11;

   // Operation codes on req_op.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Register indexes on the configuration port.
   localparam logic CSR_GRID_U = 1'b0;
   localparam logic CSR_GRID_V = 1'b1;

   // Last term of the 4 x 4 weighted sum and last Bernstein weight.
   localparam logic [TERM_W-1:0] TERM_LAST = 4'd15;
   localparam logic [WSEL_W-1:0] WSEL_LAST = 2'd3;

   // Fraction bits of the Bernstein weights for a given coordinate width.
   function automatic int weight_bits(input int cw);
      return ((62 - cw) < 26) ? (62 - cw) : 26;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_CUBE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MAC,
      ST_DRAIN
   } bbpe_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_we;
      logic              latch;
      logic              dim;
      logic              calc_sq;
      logic              calc_cube;
      logic              div_start;
      logic              wt_store;
      logic [WSEL_W-1:0] wt_sel;
      logic              mac_issue;
      logic [TERM_W-1:0] term;
      logic              finish;
   } bbpe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic pipe_busy;
   } bbpe_status_type;

endpackage

>>> design/bicubic_bezier_patch_eval_unit.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_unit: bicubic Bezier patch evaluator
// Sequence: a load word is written in the cycle it is taken. An evaluate
//   word runs eight serial divisions of WEIGHT_BITS+1 steps each and then
//   16 MAC issues, taking no new word meanwhile; busy drops in the result
//   cycle, so the next word can be taken there. Results cannot be stalled.
// Reset: synchronous, active high; clears the sequencer and sets both grid
//   registers to 11. The control point store is not cleared.
// ----------------------------------------------------------------------------
//
// A load word (req_op low) writes control point req_ctrl_index into the
// store in the cycle it is taken and leaves busy low. An evaluate word
// (req_op high) runs the sequence below, holding busy high throughout:
//
//   For u and then v, the grid size is clamped to [2, GRID_MAX], the index
//   to the last grid point, and the cubic Bernstein numerators b^3, 3ab^2,
//   3a^2b and a^3 are formed over two multiply stages. Each numerator is
//   then divided by d^3 with rounding in a shared bit-serial divider,
//   giving a weight with WEIGHT_BITS fraction bits.
//
//   The 16 control points are then streamed from the store, one per cycle,
//   through a four-stage pipeline: 2-D weight product, rounding, scaling by
//   the control point, and accumulation, with one multiplier per axis.
//
//   The sums are rounded half up, saturated to the coordinate range and
//   shown on the rsp_surf ports for one cycle under rsp_strobe.
//
// The grid registers are written on the csr port and must only change
// while the block is not busy.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_unit
   import bbpe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int GRID_MAX    = GRID_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [CPT_IDX_W-1:0]          req_ctrl_index,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_z,
   input  logic [IDX_W-1:0]              req_grid_i,
   input  logic [IDX_W-1:0]              req_grid_j,
   // Result channel
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_x,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_y,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_z,
   // Configuration port
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [GRID_REG_W-1:0]         csr_wdata
);

   // Weight precision follows from the coordinate width so that the full
   // 16-term sum stays inside the accumulator.
   localparam int WEIGHT_BITS = weight_bits(COORD_WIDTH);

   bbpe_cmd_type    cmd;
   bbpe_status_type stat;

   bbpe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   bbpe_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .GRID_MAX    (GRID_MAX),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_ctrl_index (req_ctrl_index),
      .req_ctrl_x     (req_ctrl_x),
      .req_ctrl_y     (req_ctrl_y),
      .req_ctrl_z     (req_ctrl_z),
      .req_grid_i     (req_grid_i),
      .req_grid_j     (req_grid_j),
      .rsp_strobe     (rsp_strobe),
      .rsp_surf_x     (rsp_surf_x),
      .rsp_surf_y     (rsp_surf_y),
      .rsp_surf_z     (rsp_surf_z)
   );

endmodule

>>> design/bbpe_div.sv
// ----------------------------------------------------------------------------
// bbpe_div: restoring divider, one quotient bit per cycle
// The caller guarantees that the quotient fits in QW bits, so the remainder
// is preloaded with the upper dividend bits and only QW steps are run.
// ----------------------------------------------------------------------------
module bbpe_div
   import bbpe_pkg::*;
#(
   parameter int NW  = 56,
   parameter int DVW = 30,
   parameter int QW  = 27
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NW-1:0]  dividend,
   input  logic [DVW-1:0] divisor,
   output logic [QW-1:0]  quotient,
   output logic           done
);

   localparam int CNT_W = $clog2(QW + 1);

   logic [DVW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]    sh_ff, sh_in;
   logic [DVW-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [DVW:0]     trial;
   logic             ge;

   assign done     = run_ff && (cnt_ff == CNT_W'(QW));
   assign quotient = sh_ff;

   always_comb begin
      trial  = {rem_ff, sh_ff[QW-1]};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = rem_ff;
      sh_in  = sh_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         rem_in = DVW'(dividend[NW-1:QW]);
         sh_in  = dividend[QW-1:0];
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         rem_in = ge ? DVW'(trial - {1'b0, dvs_ff}) : DVW'(trial);
         sh_in  = {sh_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> design/bbpe_datapath.sv
// ----------------------------------------------------------------------------
// bbpe_datapath: control point store, weight unit and multiply-accumulate
// Holds the grid registers, forms the Bernstein weights through a shared
// divider and sums the 16 weighted control points per axis.
// ----------------------------------------------------------------------------
module bbpe_datapath
   import bbpe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int GRID_MAX    = GRID_MAX_DEF,
   parameter int WEIGHT_BITS = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bbpe_cmd_type                  cmd,
   output bbpe_status_type               stat,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [GRID_REG_W-1:0]         csr_wdata,
   input  logic [CPT_IDX_W-1:0]          req_ctrl_index,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_z,
   input  logic [IDX_W-1:0]              req_grid_i,
   input  logic [IDX_W-1:0]              req_grid_j,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_x,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_y,
   output logic signed [COORD_WIDTH-1:0] rsp_surf_z
);

   localparam int CW    = COORD_WIDTH;
   localparam int W     = WEIGHT_BITS;
   localparam int DW    = $clog2(GRID_MAX);
   localparam int DW2   = 2 * DW;
   localparam int DW3   = 3 * DW;
   localparam int QW    = W + 1;
   localparam int NW    = DW3 + W;
   localparam int PW    = 2 * QW;
   localparam int PRW   = CW + QW + 1;
   localparam int ACC_W = CW + W + 6;
   localparam int CMP_W = ($clog2(GRID_MAX + 1) > GRID_REG_W) ?
                          ($clog2(GRID_MAX + 1) + 1) : (GRID_REG_W + 1);

   localparam logic [PW-1:0]    W_HALF   = PW'(1) << (W - 1);
   localparam logic [ACC_W-1:0] ACC_HALF = {{(ACC_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [ACC_W-1:0] SAT_HI   = {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [ACC_W-1:0] SAT_LO   = {{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Grid registers and latched indices.
   logic [GRID_REG_W-1:0] grid_u_ff, grid_v_ff;
   logic [IDX_W-1:0]      idx_i_ff, idx_j_ff;

   // Bernstein numerator pipeline.
   logic [CMP_W-1:0] grid_ext, gclamp, dmax, idx_ext, aclamp, bval;
   logic [DW-1:0]    a_t, b_t, d_t;
   logic [DW-1:0]    a_ff, b_ff, d_ff;
   logic [DW2-1:0]   aa_ff, bb_ff, dd_ff;
   logic [DW3-1:0]   aaa_ff, bbb_ff, abb_ff, aab_ff, ddd_ff;
   logic [DW3-1:0]   num_sel;
   logic [NW-1:0]    dividend;
   logic [QW-1:0]    quotient;
   logic             div_done;

   logic [QW-1:0] wu_ff [4];
   logic [QW-1:0] wv_ff [4];

   // Control point store, one memory per axis.
   logic [CW-1:0] cpt_mem [3][16];
   logic signed [CW-1:0] ctrl_wr [3];

   // Multiply-accumulate pipeline.
   logic                    v1_ff, v2_ff, v3_ff;
   logic [PW-1:0]           wprod_ff, wsum;
   logic [QW-1:0]           w_ff;
   logic signed [CW-1:0]    rd_ff [3];
   logic signed [CW-1:0]    p_ff [3];
   logic signed [PRW-1:0]   prod_ff [3];
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] tsum [3];
   logic signed [ACC_W-1:0] qv [3];
   logic signed [CW-1:0]    sat [3];
   logic signed [CW-1:0]    surf_ff [3];
   logic                    strobe_ff;

   assign ctrl_wr[0] = req_ctrl_x;
   assign ctrl_wr[1] = req_ctrl_y;
   assign ctrl_wr[2] = req_ctrl_z;

   assign rsp_strobe = strobe_ff;
   assign rsp_surf_x = surf_ff[0];
   assign rsp_surf_y = surf_ff[1];
   assign rsp_surf_z = surf_ff[2];

   assign stat.div_done  = div_done;
   assign stat.pipe_busy = v1_ff | v2_ff | v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_u_ff <= GRID_RESET;
         grid_v_ff <= GRID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_U: grid_u_ff <= csr_wdata;
            CSR_GRID_V: grid_v_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         idx_i_ff <= req_grid_i;
         idx_j_ff <= req_grid_j;
      end
   end

   // Clamp the grid size and the index for the direction being worked on.
   always_comb begin
      grid_ext = CMP_W'(cmd.dim ? grid_v_ff : grid_u_ff);
      idx_ext  = CMP_W'(cmd.dim ? idx_j_ff : idx_i_ff);
      if (grid_ext < CMP_W'(2)) begin
         gclamp = CMP_W'(2);
      end else if (grid_ext > CMP_W'(GRID_MAX)) begin
         gclamp = CMP_W'(GRID_MAX);
      end else begin
         gclamp = grid_ext;
      end
      dmax   = gclamp - CMP_W'(1);
      aclamp = (idx_ext > dmax) ? dmax : idx_ext;
      bval   = dmax - aclamp;
      a_t    = DW'(aclamp);
      b_t    = DW'(bval);
      d_t    = DW'(dmax);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_sq) begin
         a_ff  <= a_t;
         b_ff  <= b_t;
         d_ff  <= d_t;
         aa_ff <= DW2'(a_t) * DW2'(a_t);
         bb_ff <= DW2'(b_t) * DW2'(b_t);
         dd_ff <= DW2'(d_t) * DW2'(d_t);
      end
      if (cmd.calc_cube) begin
         aaa_ff <= DW3'(aa_ff) * DW3'(a_ff);
         bbb_ff <= DW3'(bb_ff) * DW3'(b_ff);
         abb_ff <= DW3'(bb_ff) * DW3'(a_ff);
         aab_ff <= DW3'(aa_ff) * DW3'(b_ff);
         ddd_ff <= DW3'(dd_ff) * DW3'(d_ff);
      end
   end

   // Numerators b^3, 3ab^2, 3a^2b, a^3; each is at most d^3.
   always_comb begin
      case (cmd.wt_sel)
         2'd0:    num_sel = bbb_ff;
         2'd1:    num_sel = DW3'({abb_ff, 1'b0}) + abb_ff;
         2'd2:    num_sel = DW3'({aab_ff, 1'b0}) + aab_ff;
         default: num_sel = aaa_ff;
      endcase
      dividend = {num_sel, {W{1'b0}}} + NW'(ddd_ff >> 1);
   end

   bbpe_div #(
      .NW  (NW),
      .DVW (DW3),
      .QW  (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (ddd_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.wt_store) begin
         if (cmd.dim) begin
            wv_ff[cmd.wt_sel] <= quotient;
         end else begin
            wu_ff[cmd.wt_sel] <= quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         for (int ax = 0; ax < 3; ax++) begin
            cpt_mem[ax][req_ctrl_index] <= ctrl_wr[ax];
         end
      end
      for (int ax = 0; ax < 3; ax++) begin
         rd_ff[ax] <= cpt_mem[ax][cmd.term];
      end
   end

   // Stage 1: 2-D weight product. Stage 2: round it. Stage 3: scale the
   // control point. Stage 4: accumulate.
   assign wsum = wprod_ff + W_HALF;

   always_ff @(posedge clock) begin
      wprod_ff <= PW'(wu_ff[cmd.term[3:2]]) * PW'(wv_ff[cmd.term[1:0]]);
      w_ff     <= wsum[W+QW-1:W];
      for (int ax = 0; ax < 3; ax++) begin
         p_ff[ax]    <= rd_ff[ax];
         prod_ff[ax] <= p_ff[ax] * $signed({1'b0, w_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int ax = 0; ax < 3; ax++) begin
         if (cmd.latch) begin
            acc_ff[ax] <= '0;
         end else if (v3_ff) begin
            acc_ff[ax] <= acc_ff[ax] + ACC_W'(prod_ff[ax]);
         end
      end
   end

   // Round half up, drop the weight fraction, then saturate.
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         tsum[ax] = acc_ff[ax] + $signed(ACC_HALF);
         qv[ax]   = tsum[ax] >>> W;
         if (qv[ax] > $signed(SAT_HI)) begin
            sat[ax] = CW'(SAT_HI);
         end else if (qv[ax] < $signed(SAT_LO)) begin
            sat[ax] = CW'(SAT_LO);
         end else begin
            sat[ax] = CW'(qv[ax]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         for (int ax = 0; ax < 3; ax++) begin
            surf_ff[ax] <= sat[ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
      end
   end

endmodule

>>> design/bbpe_ctrl.sv
// ----------------------------------------------------------------------------
// bbpe_ctrl: sequencer for the patch evaluator
// Walks each evaluate word through the numerator, weight and accumulate
// phases and issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module bbpe_ctrl
   import bbpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_op,
   input  bbpe_status_type stat,
   output bbpe_cmd_type    cmd,
   output logic            busy
);

   bbpe_state_type    state_ff, state_in;
   logic              dim_ff, dim_in;
   logic [WSEL_W-1:0] k_ff, k_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic              accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dim_ff   <= 1'b0;
         k_ff     <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
         k_ff     <= k_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      dim_in        = dim_ff;
      k_in          = k_ff;
      term_in       = term_ff;
      cmd           = '0;
      cmd.dim       = dim_ff;
      cmd.wt_sel    = k_ff;
      cmd.term      = term_ff;
      cmd.load_we   = accept && (req_op == OP_LOAD);
      cmd.latch     = accept && (req_op == OP_EVAL);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.latch) begin
               dim_in   = 1'b0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.calc_sq = 1'b1;
            state_in    = ST_CUBE;
         end
         ST_CUBE: begin
            cmd.calc_cube = 1'b1;
            k_in          = '0;
            state_in      = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.wt_store = 1'b1;
               if (k_ff != WSEL_LAST) begin
                  k_in     = k_ff + WSEL_W'(1);
                  state_in = ST_DIV_START;
               end else if (dim_ff) begin
                  term_in  = '0;
                  state_in = ST_MAC;
               end else begin
                  dim_in   = 1'b1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (term_ff == TERM_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               term_in = term_ff + TERM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/bbpe_checker.sv
// ----------------------------------------------------------------------------
// bbpe_checker: port-level checks for the patch evaluator
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
module bbpe_checker
   import bbpe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_strobe
);

   // A load word is absorbed at once and never occupies the block.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_LOAD)) |=> !busy)
      else $error("load word left the block busy");

   // An evaluate word always starts a sequence.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_EVAL)) |=> busy)
      else $error("evaluate word did not raise busy");

   // A result is shown for a single cycle only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // The block only becomes free again by delivering its result.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a result");

endmodule

bind bicubic_bezier_patch_eval_unit bbpe_checker u_bbpe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_op     (req_op),
   .rsp_strobe (rsp_strobe)
);

>>> tb/sv/bbpe_surface_checker.sv
// ----------------------------------------------------------------------------
// bbpe_surface_checker: result checker for the bicubic Bezier patch evaluator
// Watches the request, result and configuration ports, keeps its own copy of
// the control point store and grid registers, predicts every surface point
// and compares it with the word on the result port.
// ----------------------------------------------------------------------------
module bbpe_surface_checker
   import bbpe_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_op,
   input  logic [CPT_IDX_W-1:0] req_ctrl_index,
   input  logic signed [CW-1:0] req_ctrl_x,
   input  logic signed [CW-1:0] req_ctrl_y,
   input  logic signed [CW-1:0] req_ctrl_z,
   input  logic [IDX_W-1:0]     req_grid_i,
   input  logic [IDX_W-1:0]     req_grid_j,
   input  logic                 rsp_strobe,
   input  logic signed [CW-1:0] rsp_surf_x,
   input  logic signed [CW-1:0] rsp_surf_y,
   input  logic signed [CW-1:0] rsp_surf_z,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [GRID_REG_W-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending_words,
   output int                   points_checked,
   output int                   loads_seen
);

   // Fraction bits of the Bernstein weights.
   localparam int WEIGHT_FRAC = ((62 - CW) < 26) ? (62 - CW) : 26;
   localparam int WGT_W       = WEIGHT_FRAC + 1;
   localparam longint SAT_HI = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (CW - 1));

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } surf_point_type;

   typedef logic [3:0][WEIGHT_FRAC:0] weight_set_type;

   logic [GRID_REG_W-1:0] grid_u_reg;
   logic [GRID_REG_W-1:0] grid_v_reg;
   longint                patch_x [16];
   longint                patch_y [16];
   longint                patch_z [16];
   surf_point_type        expected_points [$];
   surf_point_type        want;

   // The four cubic Bernstein weights for one direction, rounded to nearest.
   function automatic weight_set_type bernstein_weights(input logic [GRID_REG_W-1:0] grid,
                                                        input logic [IDX_W-1:0] idx);
      longint unsigned d;
      longint unsigned a;
      longint unsigned b;
      longint unsigned d3;
      longint unsigned num [4];
      weight_set_type  w;
      if (grid < 2) begin
         d = 1;
      end else if (grid > GRID_MAX_DEF) begin
         d = GRID_MAX_DEF - 1;
      end else begin
         d = grid - 1;
      end
      a  = (idx > d) ? d : idx;
      b  = d - a;
      d3 = d * d * d;
      num[0] = b * b * b;
      num[1] = 3 * a * b * b;
      num[2] = 3 * a * a * b;
      num[3] = a * a * a;
      for (int k = 0; k < 4; k++) begin
         w[k] = WGT_W'(((num[k] << WEIGHT_FRAC) + d3 / 2) / d3);
      end
      return w;
   endfunction

   // Round half up out of the weight fraction, then clip to the coordinate range.
   function automatic logic signed [CW-1:0] round_saturate(input longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return q[CW-1:0];
   endfunction

   function automatic surf_point_type surface_point(input logic [IDX_W-1:0] gi,
                                                    input logic [IDX_W-1:0] gj);
      weight_set_type  wu;
      weight_set_type  wv;
      longint unsigned prod;
      longint          w2;
      longint          ax;
      longint          ay;
      longint          az;
      surf_point_type  p;
      wu = bernstein_weights(grid_u_reg, gi);
      wv = bernstein_weights(grid_v_reg, gj);
      ax = 0;
      ay = 0;
      az = 0;
      for (int m = 0; m < 4; m++) begin
         for (int n = 0; n < 4; n++) begin
            prod = wu[m] * wv[n];
            w2   = longint'((prod + (longint'(1) << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC);
            ax  += patch_x[m*4+n] * w2;
            ay  += patch_y[m*4+n] * w2;
            az  += patch_z[m*4+n] * w2;
         end
      end
      p.x = round_saturate(ax);
      p.y = round_saturate(ay);
      p.z = round_saturate(az);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         grid_u_reg = GRID_RESET;
         grid_v_reg = GRID_RESET;
         expected_points.delete();
         fail_count     = 0;
         points_checked = 0;
         loads_seen     = 0;
      end else begin
         // Results are checked before new words are taken, so a word accepted
         // in the result cycle never meets its own expectation early.
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected surface point (%h %h %h)",
                           rsp_surf_x, rsp_surf_y, rsp_surf_z);
               end
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (want.x !== rsp_surf_x || want.y !== rsp_surf_y ||
                   want.z !== rsp_surf_z) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("surface point %0d mismatch: expected (%h %h %h) got (%h %h %h)",
                              points_checked, want.x, want.y, want.z,
                              rsp_surf_x, rsp_surf_y, rsp_surf_z);
                  end
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_GRID_U) begin
               grid_u_reg = csr_wdata;
            end else begin
               grid_v_reg = csr_wdata;
            end
         end
         if (start && !busy) begin
            if (req_op == OP_LOAD) begin
               patch_x[req_ctrl_index] = longint'(req_ctrl_x);
               patch_y[req_ctrl_index] = longint'(req_ctrl_y);
               patch_z[req_ctrl_index] = longint'(req_ctrl_z);
               loads_seen++;
            end else begin
               expected_points.insert(expected_points.size(),
                                      surface_point(req_grid_i, req_grid_j));
            end
         end
      end
      pending_words = expected_points.size();
   end

endmodule

>>> tb/sv/bicubic_bezier_patch_eval_unit_test.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_unit_test: top of the patch evaluator testbench
// Loads control point patches and evaluates grid samples under a series of
// grid sizes, including out-of-range sizes and indices past the grid, while
// a separate checker predicts and compares every surface point.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_unit_test;
   import bbpe_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;

   // Each phase reloads the patch and then sends a random mix of words.
   localparam int PHASE_WORDS = 160;
   localparam int NUM_PHASES  = 12;
   localparam int FIXED_SETS  = 7;

   // This margin covers a whole evaluate word, should the block still be working
   // after the last expected point has arrived.
   localparam int DRAIN_CYCLES = 300;

   // Worst case is every word an evaluation behind the longest gap; the limit
   // allows several times that.
   localparam int CYCLE_LIMIT = 2_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_op;
   logic [CPT_IDX_W-1:0]  req_ctrl_index;
   logic signed [CW-1:0]  req_ctrl_x;
   logic signed [CW-1:0]  req_ctrl_y;
   logic signed [CW-1:0]  req_ctrl_z;
   logic [IDX_W-1:0]      req_grid_i;
   logic [IDX_W-1:0]      req_grid_j;
   logic                  rsp_strobe;
   logic signed [CW-1:0]  rsp_surf_x;
   logic signed [CW-1:0]  rsp_surf_y;
   logic signed [CW-1:0]  rsp_surf_z;
   logic                  csr_we;
   logic                  csr_index;
   logic [GRID_REG_W-1:0] csr_wdata;

   int fail_count;
   int pending_words;
   int points_checked;
   int loads_seen;

   // Clamped grid sizes, used only to aim indices at the live grid.
   int eff_u;
   int eff_v;
   int words_sent;
   int settings_used;

   int unsigned fixed_u [FIXED_SETS] = '{2, 1024, 0, 2047, 3, 1024, 11};
   int unsigned fixed_v [FIXED_SETS] = '{2, 1024, 1, 1025, 1024, 2, 11};

   always #1 clock = ~clock;

   bicubic_bezier_patch_eval_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_ctrl_index (req_ctrl_index),
      .req_ctrl_x     (req_ctrl_x),
      .req_ctrl_y     (req_ctrl_y),
      .req_ctrl_z     (req_ctrl_z),
      .req_grid_i     (req_grid_i),
      .req_grid_j     (req_grid_j),
      .rsp_strobe     (rsp_strobe),
      .rsp_surf_x     (rsp_surf_x),
      .rsp_surf_y     (rsp_surf_y),
      .rsp_surf_z     (rsp_surf_z),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   bbpe_surface_checker #(.CW(CW)) surface_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_ctrl_index (req_ctrl_index),
      .req_ctrl_x     (req_ctrl_x),
      .req_ctrl_y     (req_ctrl_y),
      .req_ctrl_z     (req_ctrl_z),
      .req_grid_i     (req_grid_i),
      .req_grid_j     (req_grid_j),
      .rsp_strobe     (rsp_strobe),
      .rsp_surf_x     (rsp_surf_x),
      .rsp_surf_y     (rsp_surf_y),
      .rsp_surf_z     (rsp_surf_z),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_words  (pending_words),
      .points_checked (points_checked),
      .loads_seen     (loads_seen)
   );

   // Watchdog: a hung handshake or a missing surface point ends the run here.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("bicubic_bezier_patch_eval_unit test failed");
      $finish;
   end

   // Present one word at the falling edge and hold it until the block takes
   // it. The block's busy flag changes only on rising edges, so the value
   // seen right after an edge is the one that edge used. Back-to-back words
   // keep start high, with one assignment per falling edge.
   task automatic send_word(input logic op, input logic [CPT_IDX_W-1:0] idx,
                            input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [CW-1:0] z, input logic [IDX_W-1:0] gi,
                            input logic [IDX_W-1:0] gj);
      @(negedge clock);
      start          <= 1'b1;
      req_op         <= op;
      req_ctrl_index <= idx;
      req_ctrl_x     <= x;
      req_ctrl_y     <= y;
      req_ctrl_z     <= z;
      req_grid_i     <= gi;
      req_grid_j     <= gj;
      do begin
         @(posedge clock);
      end while (busy);
      words_sent++;
   endtask

   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Stop sending, let every expected surface point come back, then give the
   // block its full latency so that a trailing load is surely finished too.
   task automatic wait_idle();
      pause(1);
      while (pending_words != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Both grid registers are written only while the block is idle.
   task automatic write_grid(input logic [GRID_REG_W-1:0] u,
                             input logic [GRID_REG_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_U;
      csr_wdata <= u;
      @(negedge clock);
      csr_index <= CSR_GRID_V;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      eff_u = (u < 2) ? 2 : (u > GRID_MAX_DEF) ? GRID_MAX_DEF : u;
      eff_v = (v < 2) ? 2 : (v > GRID_MAX_DEF) ? GRID_MAX_DEF : v;
      settings_used++;
   endtask

   // Coordinates come in three flavors: any bit pattern, small values around
   // zero, and the range extremes that drive the sums into saturation.
   function automatic logic [CW-1:0] random_coord(input int flavor);
      logic [CW-1:0] v;
      case (flavor)
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         default: begin
            case ($urandom_range(0, 4))
               0: v = {1'b0, {(CW-1){1'b1}}};
               1: v = {1'b1, {(CW-1){1'b0}}};
               2: v = '0;
               3: v = '1;
               default: v = 1;
            endcase
         end
      endcase
      return v;
   endfunction

   // Mostly indices inside the live grid, with its two ends favored and a
   // share over the whole field so that clamping is exercised.
   function automatic logic [IDX_W-1:0] pick_index(input int eff);
      int v;
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = eff - 1;
         2, 3:    v = $urandom_range(0, 1023);
         default: v = $urandom_range(0, eff - 1);
      endcase
      return IDX_W'(v);
   endfunction

   // One phase: a fresh patch of 16 control points in one flavor, then loads
   // and evaluations mixed at random. The sender works in bursts separated
   // by gaps of random length, so words meet the block both busy and idle.
   task automatic run_phase(input int words);
      int flavor;
      int burst_left;
      int gap;
      flavor     = $urandom_range(0, 2);
      burst_left = 0;
      for (int k = 0; k < words; k++) begin
         if (burst_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1:    gap = 0;
               2, 3:    gap = $urandom_range(5, 30);
               default: gap = $urandom_range(1, 4);
            endcase
            pause(gap);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         if (k < 16) begin
            send_word(OP_LOAD, k[CPT_IDX_W-1:0], random_coord(flavor),
                      random_coord(flavor), random_coord(flavor),
                      IDX_W'($urandom), IDX_W'($urandom));
         end else if ($urandom_range(0, 9) < 4) begin
            send_word(OP_LOAD, CPT_IDX_W'($urandom),
                      random_coord($urandom_range(0, 2)),
                      random_coord($urandom_range(0, 2)),
                      random_coord($urandom_range(0, 2)),
                      IDX_W'($urandom), IDX_W'($urandom));
         end else begin
            // The control point fields of an evaluate word carry noise.
            send_word(OP_EVAL, CPT_IDX_W'($urandom), $urandom, $urandom, $urandom,
                      pick_index(eff_u), pick_index(eff_v));
         end
      end
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_LOAD;
      req_ctrl_index = '0;
      req_ctrl_x     = '0;
      req_ctrl_y     = '0;
      req_ctrl_z     = '0;
      req_grid_i     = '0;
      req_grid_j     = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_GRID_U;
      csr_wdata      = '0;
      eff_u          = GRID_RESET;
      eff_v          = GRID_RESET;
      words_sent     = 0;
      settings_used  = 1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part, on the grid sizes left by reset. The store is not
      // cleared, so all 16 control points are loaded before any evaluation:
      // x at the largest value, y at the smallest, z alternating between the
      // two. The sums then sit at the range edges and may saturate.
      for (int k = 0; k < 16; k++) begin
         send_word(OP_LOAD, k[CPT_IDX_W-1:0], {1'b0, {(CW-1){1'b1}}},
                   {1'b1, {(CW-1){1'b0}}},
                   k[0] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}},
                   k[0] ? '1 : '0, k[0] ? '0 : '1);
      end
      // Grid corners, the last grid point, indices past the grid on either
      // side, and two interior samples.
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd0, 10'd0);
      send_word(OP_EVAL, '1, '1, '1, '1, 10'd10, 10'd10);
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd1023, 10'd1023);
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd0, 10'd1023);
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd1023, 10'd0);
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd5, 10'd5);
      send_word(OP_EVAL, '0, '0, '0, '0, 10'd3, 10'd7);
      wait_idle();

      // Random part. The first settings are fixed to hit the smallest and
      // largest grids and sizes outside the legal range; later ones are
      // mostly small grids with an occasional value anywhere in the field.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < FIXED_SETS) begin
            write_grid(GRID_REG_W'(fixed_u[p]), GRID_REG_W'(fixed_v[p]));
         end else if ($urandom_range(0, 9) < 7) begin
            write_grid(GRID_REG_W'($urandom_range(2, 64)),
                       GRID_REG_W'($urandom_range(2, 64)));
         end else begin
            write_grid(GRID_REG_W'($urandom_range(0, 2047)),
                       GRID_REG_W'($urandom_range(0, 2047)));
         end
         run_phase(PHASE_WORDS);
      end

      $display("Run covered %0d words: %0d control point loads and %0d surface points checked,",
               words_sent, loads_seen, points_checked);
      $display("across %0d grid settings, with clamped sizes, clamped indices and saturation.",
               settings_used);
      if (fail_count == 0) begin
         $display("bicubic_bezier_patch_eval_unit test passed");
      end else begin
         $display("bicubic_bezier_patch_eval_unit test failed");
      end
      $finish;
   end

endmodule
